### src/ddnc_pkg.sv
// ----------------------------------------------------------------------------
// ddnc_pkg: shared types and constants of the day number converter
// Sequencer states, calendar constants and the month length lookup.
// ----------------------------------------------------------------------------
package ddnc_pkg;

  localparam int unsigned DayNumberW = 17;
  localparam int unsigned DayW       = 5;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned YearW      = 12;
  localparam int unsigned LenW       = 9;

  localparam logic [YearW-1:0]      BaseYear     = 12'd1900;
  localparam logic [DayNumberW-1:0] DayNumberMax = 17'd131071;
  localparam logic [LenW-1:0]       DaysYear     = 9'd365;
  localparam logic [LenW-1:0]       DaysLeapYear = 9'd366;
  localparam logic [MonthW-1:0]     MonthFirst   = 4'd1;
  localparam logic [MonthW-1:0]     MonthLast    = 4'd12;
  localparam logic [8:0]            Mod400Base   = 9'd300;  // 1900 mod 400
  localparam logic [6:0]            Mod100Last   = 7'd99;
  localparam logic [8:0]            Mod400Last   = 9'd399;

  localparam logic ActEncode = 1'b0;
  localparam logic ActDecode = 1'b1;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StYears  = 4'b0010,
    StMonths = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  function automatic logic [DayW-1:0] days_in_month(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### src/date_day_number_converter.sv
// ----------------------------------------------------------------------------
// date_day_number_converter
// Converts between a day number (1 Jan 1900 is day 1) and a Gregorian date.
// ----------------------------------------------------------------------------
// One request at a time: with action 0 the date is encoded by adding whole
// years from 1900, whole months of the target year and then the day; with
// action 1 the day number is decoded by subtracting whole years and then whole
// months, each compared against its true length. A single add/subtract and
// compare unit does one year or one month per cycle. A request rejected at
// entry skips the year and month steps and goes straight to the finish state.
// Leap years are tracked with running mod 4/100/400 counters. The result sits
// in an output register, so a new request is taken while the previous result
// waits. Out-of-range years, months, day number zero, day numbers past the last
// supported year and encoded sums above 131071 flag range_error with all numeric
// outputs zero.
module date_day_number_converter #(
  parameter int unsigned YEAR_SPAN = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [ddnc_pkg::DayNumberW-1:0]   day_number_i,
  input  logic [ddnc_pkg::DayW-1:0]         in_day_i,
  input  logic [ddnc_pkg::MonthW-1:0]       in_month_i,
  input  logic [ddnc_pkg::YearW-1:0]        in_year_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ddnc_pkg::DayNumberW-1:0]   out_day_number_o,
  output logic [ddnc_pkg::DayW-1:0]         out_day_o,
  output logic [ddnc_pkg::MonthW-1:0]       out_month_o,
  output logic [ddnc_pkg::YearW-1:0]        out_year_o,
  output logic                              range_error_o
);
  import ddnc_pkg::*;

  localparam int unsigned EncMax = YEAR_SPAN * 366 + 366;
  localparam int unsigned AccW   = (EncMax > 131071) ? $clog2(EncMax + 1) : DayNumberW;
  localparam logic [YearW-1:0] LastYear = YearW'(1900 + YEAR_SPAN - 1);

  state_e              state_q, state_d;
  logic                action_q, action_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [YearW-1:0]    y_q, y_d, year_q, year_d;
  logic [MonthW-1:0]   m_q, m_d, month_q, month_d;
  logic [DayW-1:0]     day_q, day_d;
  logic [1:0]          mod4_q, mod4_d;
  logic [6:0]          mod100_q, mod100_d;
  logic [8:0]          mod400_q, mod400_d;
  logic                err_q, err_d;

  logic                    out_valid_q, out_valid_d;
  logic [DayNumberW-1:0]   out_dn_q, out_dn_d;
  logic [DayW-1:0]         out_day_q, out_day_d;
  logic [MonthW-1:0]       out_month_q, out_month_d;
  logic [YearW-1:0]        out_year_q, out_year_d;
  logic                    out_err_q, out_err_d;

  // shared add/subtract and compare unit
  logic                leap;
  logic [LenW-1:0]     year_len;
  logic [LenW-1:0]     month_len;
  logic [LenW-1:0]     opnd;
  logic                sub;
  logic [AccW-1:0]     alu_res;
  logic                acc_gt;

  assign leap      = (mod4_q == 2'd0) && !((mod100_q == 7'd0) && (mod400_q != 9'd0));
  assign year_len  = leap ? DaysLeapYear : DaysYear;
  assign month_len = LenW'(days_in_month(m_q, leap));
  assign alu_res   = sub ? (acc_q - AccW'(opnd)) : (acc_q + AccW'(opnd));
  assign acc_gt    = acc_q > AccW'(opnd);

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    acc_d       = acc_q;
    y_d         = y_q;
    m_d         = m_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    mod4_d      = mod4_q;
    mod100_d    = mod100_q;
    mod400_d    = mod400_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dn_d    = out_dn_q;
    out_day_d   = out_day_q;
    out_month_d = out_month_q;
    out_year_d  = out_year_q;
    out_err_d   = out_err_q;
    opnd        = year_len;
    sub         = (action_q == ActDecode);

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          action_d = action_i;
          year_d   = in_year_i;
          month_d  = in_month_i;
          day_d    = in_day_i;
          y_d      = BaseYear;
          m_d      = MonthFirst;
          mod4_d   = 2'd0;
          mod100_d = 7'd0;
          mod400_d = Mod400Base;
          if (action_i == ActDecode) begin
            acc_d   = AccW'(day_number_i);
            err_d   = (day_number_i == '0);
          end else begin
            acc_d   = '0;
            err_d   = (in_year_i < BaseYear) || (in_year_i > LastYear) ||
                      (in_month_i < MonthFirst) || (in_month_i > MonthLast);
          end
          state_d = err_d ? StFinish : StYears;
        end
      end
      StYears: begin
        opnd = year_len;
        if (action_q == ActEncode) begin
          if (y_q == year_q) begin
            state_d = StMonths;
          end else begin
            acc_d = alu_res;
          end
        end else if (y_q > LastYear) begin
          err_d   = 1'b1;
          state_d = StFinish;
        end else if (!acc_gt) begin
          state_d = StMonths;
        end else begin
          acc_d = alu_res;
        end
        // advance the year and its leap counters
        if ((state_d == StYears) && (state_q == StYears)) begin
          y_d      = y_q + 1'b1;
          mod4_d   = mod4_q + 1'b1;
          mod100_d = (mod100_q == Mod100Last) ? 7'd0 : mod100_q + 1'b1;
          mod400_d = (mod400_q == Mod400Last) ? 9'd0 : mod400_q + 1'b1;
        end
      end
      StMonths: begin
        if (action_q == ActEncode) begin
          if (m_q == month_q) begin
            opnd    = LenW'(day_q);
            acc_d   = alu_res;
            state_d = StFinish;
          end else begin
            opnd  = month_len;
            acc_d = alu_res;
            m_d   = m_q + 1'b1;
          end
        end else begin
          opnd = month_len;
          if (acc_gt) begin
            acc_d = alu_res;
            m_d   = m_q + 1'b1;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StFinish: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_dn_d    = '0;
          out_day_d   = '0;
          out_month_d = '0;
          out_year_d  = '0;
          out_err_d   = err_q;
          if (action_q == ActEncode) begin
            if (!err_q && (acc_q > AccW'(DayNumberMax))) begin
              out_err_d = 1'b1;
            end else if (!err_q) begin
              out_dn_d = acc_q[DayNumberW-1:0];
            end
          end else if (!err_q) begin
            out_day_d   = acc_q[DayW-1:0];
            out_month_d = m_q;
            out_year_d  = y_q;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q    <= action_d;
    acc_q       <= acc_d;
    y_q         <= y_d;
    m_q         <= m_d;
    year_q      <= year_d;
    month_q     <= month_d;
    day_q       <= day_d;
    mod4_q      <= mod4_d;
    mod100_q    <= mod100_d;
    mod400_q    <= mod400_d;
    err_q       <= err_d;
    out_dn_q    <= out_dn_d;
    out_day_q   <= out_day_d;
    out_month_q <= out_month_d;
    out_year_q  <= out_year_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_day_number_o = out_dn_q;
  assign out_day_o        = out_day_q;
  assign out_month_o      = out_month_q;
  assign out_year_o       = out_year_q;
  assign range_error_o    = out_err_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("converter stayed ready after taking a request");

  a_month_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMonths |-> (m_q >= MonthFirst) && (m_q <= MonthLast))
    else $error("month counter left 1..12");

  a_year_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StYears |-> y_q <= LastYear + 1'b1)
    else $error("year counter ran past the supported span");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> (out_day_number_o == '0) && (out_day_o == '0) &&
      (out_month_o == '0) && (out_year_o == '0))
    else $error("range error with nonzero result fields");
`endif

endmodule

### tb/sv/tb_date_day_number_converter.sv
// ----------------------------------------------------------------------------
// tb_date_day_number_converter: self-checking bench of the day number converter
// Walks a table of directed dates and day numbers, then random requests in
// three idle phases, checking results against table rows or a calendar model.
// ----------------------------------------------------------------------------
module tb_date_day_number_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import ddnc_pkg::*;

  localparam int unsigned YearSpan      = 256;
  localparam int unsigned LastYear      = BaseYear + YearSpan - 1;
  localparam int unsigned LastDayNumber = 93502;  // 256 years, 62 of them leap
  localparam int unsigned RandomPerPhase = 160;
  localparam int unsigned StallCycles   = 1500;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned QuietLimit    = 20000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned TxIdle [3] = '{32, 80, 0};
  localparam int unsigned RxIdle [3] = '{80, 32, 0};

  typedef struct packed {
    logic                  action;
    logic [DayNumberW-1:0] day_number;
    logic [DayW-1:0]       day;
    logic [MonthW-1:0]     month;
    logic [YearW-1:0]      year;
  } date_req_t;

  typedef struct packed {
    logic [DayNumberW-1:0] day_number;
    logic [DayW-1:0]       day;
    logic [MonthW-1:0]     month;
    logic [YearW-1:0]      year;
    logic                  range_error;
  } date_result_t;

  typedef struct packed {
    date_req_t    req;
    logic         exp_given;
    date_result_t res;
  } date_row_t;

  localparam date_result_t RangeErr  = '{17'd0, 5'd0, 4'd0, 12'd0, 1'b1};
  localparam date_result_t FromModel = '0;

  localparam date_row_t DateTable [24] = '{
    '{'{ActEncode, 17'd0,      5'd1,  4'd1,  12'd1900}, 1'b1, '{17'd1,  5'd0, 4'd0, 12'd0, 1'b0}},
    '{'{ActEncode, 17'd0,      5'd0,  4'd1,  12'd1900}, 1'b1, '{17'd0,  5'd0, 4'd0, 12'd0, 1'b0}},
    '{'{ActEncode, 17'd0,      5'd31, 4'd1,  12'd1900}, 1'b1, '{17'd31, 5'd0, 4'd0, 12'd0, 1'b0}},
    '{'{ActEncode, 17'd0,      5'd15, 4'd6,  12'd1899}, 1'b1, RangeErr},
    '{'{ActEncode, 17'd0,      5'd1,  4'd1,  12'd2156}, 1'b1, RangeErr},
    '{'{ActEncode, 17'd131071, 5'd31, 4'd15, 12'd4095}, 1'b1, RangeErr},
    '{'{ActEncode, 17'd0,      5'd1,  4'd0,  12'd2000}, 1'b1, RangeErr},
    '{'{ActEncode, 17'd0,      5'd1,  4'd13, 12'd2000}, 1'b1, RangeErr},
    '{'{ActEncode, 17'd0,      5'd0,  4'd0,  12'd0},    1'b1, RangeErr},
    '{'{ActEncode, 17'd0,      5'd29, 4'd2,  12'd1900}, 1'b0, FromModel},
    '{'{ActEncode, 17'd0,      5'd31, 4'd2,  12'd2000}, 1'b0, FromModel},
    '{'{ActEncode, 17'd0,      5'd31, 4'd12, 12'd2000}, 1'b0, FromModel},
    '{'{ActEncode, 17'd131071, 5'd31, 4'd12, 12'd2155}, 1'b0, FromModel},
    '{'{ActEncode, 17'd0,      5'd1,  4'd3,  12'd2100}, 1'b0, FromModel},
    '{'{ActDecode, 17'd0,      5'd31, 4'd15, 12'd4095}, 1'b1, RangeErr},
    '{'{ActDecode, 17'd1,      5'd0,  4'd0,  12'd0},    1'b1, '{17'd0, 5'd1, 4'd1, 12'd1900, 1'b0}},
    '{'{ActDecode, 17'd365,    5'd0,  4'd0,  12'd0},    1'b1, '{17'd0, 5'd31, 4'd12, 12'd1900, 1'b0}},
    '{'{ActDecode, 17'd366,    5'd0,  4'd0,  12'd0},    1'b1, '{17'd0, 5'd1, 4'd1, 12'd1901, 1'b0}},
    '{'{ActDecode, 17'd60,     5'd0,  4'd0,  12'd0},    1'b1, '{17'd0, 5'd1, 4'd3, 12'd1900, 1'b0}},
    '{'{ActDecode, 17'd1826,   5'd0,  4'd0,  12'd0},    1'b0, FromModel},
    '{'{ActDecode, 17'd36584,  5'd0,  4'd0,  12'd0},    1'b0, FromModel},
    '{'{ActDecode, 17'd93502,  5'd31, 4'd15, 12'd4095}, 1'b0, FromModel},
    '{'{ActDecode, 17'd93503,  5'd0,  4'd0,  12'd0},    1'b1, RangeErr},
    '{'{ActDecode, 17'd131071, 5'd0,  4'd0,  12'd0},    1'b1, RangeErr}
  };

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic                  action_i     = ActEncode;
  logic [DayNumberW-1:0] day_number_i = '0;
  logic [DayW-1:0]       in_day_i     = '0;
  logic [MonthW-1:0]     in_month_i   = '0;
  logic [YearW-1:0]      in_year_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [DayNumberW-1:0] out_day_number_o;
  logic [DayW-1:0]       out_day_o;
  logic [MonthW-1:0]     out_month_o;
  logic [YearW-1:0]      out_year_o;
  logic                  range_error_o;

  date_result_t pending_results [$];
  date_result_t seen_res, want_res;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_idle_pct = 0;
  bit           hold_req = 1'b0;
  int unsigned  quiet_cycles = 0;
  int unsigned  n_fail = 0, n_results = 0, n_flagged = 0;
  int unsigned  n_encode = 0, n_decode = 0;

  date_day_number_converter #(
    .YEAR_SPAN(YearSpan)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .day_number_i    (day_number_i),
    .in_day_i        (in_day_i),
    .in_month_i      (in_month_i),
    .in_year_i       (in_year_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_day_number_o(out_day_number_o),
    .out_day_o       (out_day_o),
    .out_month_o     (out_month_o),
    .out_year_o      (out_year_o),
    .range_error_o   (range_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic is_gregorian_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned year_days(int unsigned y);
    return is_gregorian_leap(y) ? DaysLeapYear : DaysYear;
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m == 2) return is_gregorian_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic date_result_t calendar_convert(date_req_t req);
    date_result_t res;
    int unsigned  acc, rest, yy, mm;
    res = '0;
    if (req.action == ActEncode) begin
      if (req.year < BaseYear || req.year > LastYear ||
          req.month < MonthFirst || req.month > MonthLast) begin
        res.range_error = 1'b1;
      end else begin
        acc = 0;
        for (yy = BaseYear; yy < req.year; yy++) acc += year_days(yy);
        for (mm = MonthFirst; mm < req.month; mm++) acc += month_days(mm, req.year);
        acc += req.day;
        if (acc > DayNumberMax) res.range_error = 1'b1;
        else res.day_number = DayNumberW'(acc);
      end
    end else if (req.day_number == 0) begin
      res.range_error = 1'b1;
    end else begin
      rest = req.day_number;
      yy   = BaseYear;
      while (yy <= LastYear && rest > year_days(yy)) begin
        rest -= year_days(yy);
        yy++;
      end
      if (yy > LastYear) begin
        res.range_error = 1'b1;
      end else begin
        mm = MonthFirst;
        while (rest > month_days(mm, yy)) begin
          rest -= month_days(mm, yy);
          mm++;
        end
        res.day   = DayW'(rest);
        res.month = MonthW'(mm);
        res.year  = YearW'(yy);
      end
    end
    return res;
  endfunction

  // Mostly well-formed dates and day numbers; unused fields always random.
  function automatic date_req_t random_request();
    date_req_t    req, probe;
    date_result_t probe_res;
    int unsigned  sel;
    req.action     = 1'($urandom_range(1, 0));
    req.day_number = DayNumberW'($urandom_range(DayNumberMax, 0));
    req.day        = DayW'($urandom_range(31, 0));
    req.month      = MonthW'($urandom_range(15, 0));
    req.year       = YearW'($urandom_range(4095, 0));
    sel = $urandom_range(99, 0);
    if (sel < 40) begin
      req.action = ActEncode;
      req.year   = YearW'($urandom_range(LastYear, BaseYear));
      req.month  = MonthW'($urandom_range(MonthLast, MonthFirst));
    end else if (sel < 60) begin
      req.action     = ActDecode;
      req.day_number = DayNumberW'($urandom_range(LastDayNumber, 1));
    end else if (sel < 80) begin
      // land on the first or last day of a month
      probe.action     = ActEncode;
      probe.day_number = '0;
      probe.year       = YearW'($urandom_range(LastYear, BaseYear));
      probe.month      = MonthW'($urandom_range(MonthLast, MonthFirst));
      probe.day        = $urandom_range(1, 0) ? DayW'(1)
                                              : DayW'(month_days(probe.month, probe.year));
      probe_res        = calendar_convert(probe);
      req.action     = ActDecode;
      req.day_number = probe_res.day_number;
    end else if (sel < 90) begin
      req.action     = ActDecode;
      req.day_number = DayNumberW'($urandom_range(DayNumberMax, LastDayNumber - 400));
    end
    return req;
  endfunction

  task automatic offer_request(input date_req_t req, input date_result_t want);
    if (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    in_valid_i   <= 1'b1;
    action_i     <= req.action;
    day_number_i <= req.day_number;
    in_day_i     <= req.day;
    in_month_i   <= req.month;
    in_year_i    <= req.year;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(want);
    if (req.action == ActEncode) n_encode++;
    else n_decode++;
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // hold off long enough for the block to back up into its input
        out_ready_i <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_res = '{out_day_number_o, out_day_o, out_month_o, out_year_o, range_error_o};
      n_results++;
      if (seen_res.range_error) n_flagged++;
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= MaxReports)
          $display("unexpected result: dn %0d date %0d/%0d/%0d err %0b",
                   seen_res.day_number, seen_res.day, seen_res.month, seen_res.year,
                   seen_res.range_error);
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res !== want_res) begin
          n_fail++;
          if (n_fail <= MaxReports)
            $display("mismatch exp/got: dn %0d/%0d d %0d/%0d m %0d/%0d y %0d/%0d err %0b/%0b",
                     want_res.day_number, seen_res.day_number, want_res.day, seen_res.day,
                     want_res.month, seen_res.month, want_res.year, seen_res.year,
                     want_res.range_error, seen_res.range_error);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no handshake for %0d cycles", QuietLimit);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    date_req_t req;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = TxIdle[0];
    rx_idle_pct = RxIdle[0];
    for (int i = 0; i < $size(DateTable); i++) begin
      offer_request(DateTable[i].req,
                    DateTable[i].exp_given ? DateTable[i].res
                                           : calendar_convert(DateTable[i].req));
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = TxIdle[ph];
      rx_idle_pct = RxIdle[ph];
      if (ph == 2) hold_req = 1'b1;
      repeat (RandomPerPhase) begin
        req = random_request();
        offer_request(req, calendar_convert(req));
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d encode and %0d decode requests, %0d results, %0d range errors",
             n_encode, n_decode, n_results, n_flagged);
    $display("ran three stall mixes plus one long output hold; %0d mismatches", n_fail);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
